@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros shared by the scheduler rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define FPS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("scheduler assertion failed");

// same-cycle implication
`define FPS_ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("scheduler assertion failed");

// next-cycle implication
`define FPS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("scheduler assertion failed");

`endif

@@ src/fps_pkg.sv @@
// ---------------------------------------------------------------------------
// fps_pkg
// types, constants and dispatch tables of the priority scheduler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

  localparam int unsigned MAX_PROCS_DEF = 64;
  localparam int unsigned PRIO_LEVELS   = 60;
  localparam int unsigned TABLE_LEN     = 60;
  localparam int unsigned TABLE_LAST_I  =
    (PRIO_LEVELS < TABLE_LEN) ? (PRIO_LEVELS - 1) : (TABLE_LEN - 1);
  localparam logic [5:0]  TABLE_LAST    = 6'(TABLE_LAST_I);

  localparam int unsigned PID_W   = 6;
  localparam int unsigned PRIO_W  = 6;
  localparam int unsigned QUANT_W = 10;
  localparam int unsigned DEPTH_W = 8;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  // item kind carried on the input tuser
  typedef enum logic [1:0] {
    ACT_RESCHED = 2'd0,
    ACT_DSTART  = 2'd1,
    ACT_DSTOP   = 2'd2,
    ACT_ENQ     = 2'd3
  } fps_action_e;

  // scheduling groups
  localparam logic [1:0] GRP_TS = 2'd0;
  localparam logic [1:0] GRP_PS = 2'd1;

  // one ready queue entry
  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
  } fps_entry_t;

  // command broadcast along the cell chain
  typedef struct packed {
    logic ins;
    logic pop;
  } fps_qcmd_t;

  localparam logic [PRIO_W-1:0] CPU_TABLE [TABLE_LEN] = '{
    6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
    6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
    6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49
  };

  localparam logic [PRIO_W-1:0] IO_TABLE [TABLE_LEN] = '{
    6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
    6'd51, 6'd51, 6'd51, 6'd51, 6'd51, 6'd51, 6'd51, 6'd51, 6'd51, 6'd51,
    6'd52, 6'd52, 6'd52, 6'd52, 6'd52, 6'd52, 6'd52, 6'd52, 6'd52, 6'd52,
    6'd53, 6'd53, 6'd53, 6'd53, 6'd53, 6'd54, 6'd54, 6'd54, 6'd54, 6'd54,
    6'd55, 6'd55, 6'd55, 6'd55, 6'd55, 6'd56, 6'd57, 6'd58, 6'd58, 6'd58,
    6'd58, 6'd58, 6'd58, 6'd58, 6'd58, 6'd58, 6'd58, 6'd58, 6'd58, 6'd59
  };

  localparam logic [7:0] QUANT_TABLE [TABLE_LEN] = '{
    8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200,
    8'd160, 8'd160, 8'd160, 8'd160, 8'd160, 8'd160, 8'd160, 8'd160, 8'd160, 8'd160,
    8'd120, 8'd120, 8'd120, 8'd120, 8'd120, 8'd120, 8'd120, 8'd120, 8'd120, 8'd120,
    8'd80,  8'd80,  8'd80,  8'd80,  8'd80,  8'd80,  8'd80,  8'd80,  8'd80,  8'd80,
    8'd40,  8'd40,  8'd40,  8'd40,  8'd40,  8'd40,  8'd40,  8'd40,  8'd40,  8'd40,
    8'd40,  8'd40,  8'd40,  8'd40,  8'd40,  8'd40,  8'd40,  8'd40,  8'd40,  8'd20
  };

  // priorities past the last table row use the last row
  function automatic logic [5:0] fps_tbl_idx(input logic [PRIO_W-1:0] prio);
    return (prio > TABLE_LAST) ? TABLE_LAST : prio;
  endfunction

  function automatic logic [PRIO_W-1:0] fps_remap(input logic [PRIO_W-1:0] prio,
                                                   input logic cpu_bound);
    logic [5:0] idx;
    idx = fps_tbl_idx(prio);
    return cpu_bound ? CPU_TABLE[idx] : IO_TABLE[idx];
  endfunction

  function automatic logic [QUANT_W-1:0] fps_quantum(input logic [PRIO_W-1:0] prio);
    return QUANT_W'(QUANT_TABLE[fps_tbl_idx(prio)]);
  endfunction

endpackage

`default_nettype wire

@@ src/fps_cell.sv @@
// ---------------------------------------------------------------------------
// fps_cell
// one slot of the sorted ready queue; shifts right on insert, left on pop
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fps_cell
  import fps_pkg::*;
(
  input  wire logic       clk_i,
  input  wire fps_qcmd_t  cmd_i,
  input  wire logic       valid_i,      // slot lies below the fill count
  input  wire logic       left_keep_i,  // left neighbor keeps its entry on insert
  input  wire fps_entry_t new_i,
  input  wire fps_entry_t left_i,
  input  wire fps_entry_t right_i,
  output fps_entry_t      entry_o,
  output logic            keep_o
);

  fps_entry_t entry_q, entry_d;

  // an equal or higher priority stays ahead of the new word
  assign keep_o = valid_i && (entry_q.prio >= new_i.prio);

  // slot update
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.pop) begin
      entry_d = right_i;
    end else if (cmd_i.ins && !keep_o) begin
      entry_d = left_keep_i ? new_i : left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

@@ src/fps_queue.sv @@
// ---------------------------------------------------------------------------
// fps_queue
// chain of cells forming the ready queue, highest priority in cell zero
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fps_queue
  import fps_pkg::*;
#(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF,
  parameter int unsigned CNT_W     = $clog2(MAX_PROCS + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fps_qcmd_t        cmd_i,
  input  wire fps_entry_t       new_i,
  input  wire logic [CNT_W-1:0] count_i,
  output fps_entry_t            head_o
);

  fps_entry_t entries [MAX_PROCS];
  logic       keeps   [MAX_PROCS];

  // cell row, each linked to both neighbors
  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    fps_entry_t left_w, right_w;
    logic       left_keep_w;

    if (i == 0) begin : g_first
      assign left_w      = new_i;
      assign left_keep_w = 1'b1;
    end else begin : g_mid
      assign left_w      = entries[i-1];
      assign left_keep_w = keeps[i-1];
    end

    if (i == MAX_PROCS - 1) begin : g_last
      assign right_w = entries[i];
    end else begin : g_inner
      assign right_w = entries[i+1];
    end

    fps_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd_i),
      .valid_i     (CNT_W'(i) < count_i),
      .left_keep_i (left_keep_w),
      .new_i       (new_i),
      .left_i      (left_w),
      .right_i     (right_w),
      .entry_o     (entries[i]),
      .keep_o      (keeps[i])
    );
  end

  assign head_o = entries[0];

  // checks
  `FPS_ASSERT_ALWAYS(a_no_ins_pop, clk_i, rst_ni, !(cmd_i.ins && cmd_i.pop))
  `FPS_ASSERT_IMPLIES(a_no_overflow, clk_i, rst_ni, cmd_i.ins, count_i < CNT_W'(MAX_PROCS))
  `FPS_ASSERT_IMPLIES(a_sorted_head, clk_i, rst_ni, count_i >= CNT_W'(2),
                      entries[0].prio >= entries[1].prio)

endmodule

`default_nettype wire

@@ src/feedback_priority_scheduler.sv @@
// ---------------------------------------------------------------------------
// feedback_priority_scheduler
// ready queue scheduler with a time-sharing dispatch table
// ---------------------------------------------------------------------------
// usage:
//  - input stream: tuser holds the action (reschedule, defer start, defer
//    stop, enqueue), tdata the process fields; one result word per input word
//  - output stream: status, dispatch flags, running process, updated
//    priority and new quantum, held in an output register
//  - config channel: writes fixed_quantum, always ready; write only when idle
//  - latency: the result is valid the cycle after the input word is taken
//  - throughput: one word per cycle while the output is taken; when a switch puts the
//    departing process back into the queue, tready drops for the insert pass
//    through the cell chain, which follows the pop pass
//  - the queue is a row of cells, each slot comparing against the inserted
//    word and shifting toward its neighbor
//  - receiver stall: tready drops while the output register is full and
//    not taken; nothing is lost
//  - reset: null process running at priority zero, queue empty, no defer
//    open, fixed_quantum 2
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module feedback_priority_scheduler
  import fps_pkg::*;
#(
  parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // config write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [QUANT_W-1:0] cfg_data_i,     // fixed_quantum
  // input stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [15:0]        s_axis_tdata,   // still_runnable, slice_expired,
                                                  // old_group[1:0], ready_pid[5:0],
                                                  // ready_priority[5:0]
  input  wire logic [1:0]         s_axis_tuser,   // action[1:0]
  // output stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [31:0]             m_axis_tdata    // status, switched, deferred,
                                                  // running_pid[5:0],
                                                  // departing_priority[5:0],
                                                  // quantum_valid, quantum[9:0],
                                                  // zero fill
);

  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_INS  = 1'b1;

  typedef struct packed {
    logic [QUANT_W-1:0] quantum;
    logic               qvalid;
    logic [PRIO_W-1:0]  dprio;
    logic [PID_W-1:0]   pid;
    logic               deferred;
    logic               switched;
    logic               status;
  } fps_result_t;

  logic               state_q, state_d;
  logic [QUANT_W-1:0] fixq_q;
  logic [PID_W-1:0]   run_pid_q, run_pid_d;
  logic [PRIO_W-1:0]  run_prio_q, run_prio_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               pend_q, pend_d;
  fps_entry_t         req_q, req_d;
  logic               mval_q, mval_d;
  fps_result_t        mres_q, mres_d;

  fps_action_e        action;
  logic               runnable, expired;
  logic [1:0]         group;
  fps_entry_t         in_entry;
  logic               accept, resched;
  logic [PRIO_W-1:0]  upd_prio;
  fps_qcmd_t          qcmd;
  fps_entry_t         qnew, head;
  fps_result_t        res;

  // field unpacking
  assign action         = fps_action_e'(s_axis_tuser);
  assign runnable       = s_axis_tdata[0];
  assign expired        = s_axis_tdata[1];
  assign group          = s_axis_tdata[3:2];
  assign in_entry.pid   = s_axis_tdata[9:4];
  assign in_entry.prio  = s_axis_tdata[15:10];

  assign cfg_ready_o    = 1'b1;
  assign s_axis_tready  = (state_q == ST_IDLE) && (!mval_q || m_axis_tready);
  assign accept         = s_axis_tvalid && s_axis_tready;

  // a reschedule runs now, or replays when the last defer closes
  assign resched = ((action == ACT_RESCHED) && (depth_q == '0)) ||
                   ((action == ACT_DSTOP) && (depth_q == DEPTH_W'(1)) && pend_q);

  // priority after classification; the null process is never remapped
  assign upd_prio = ((group == GRP_TS) && (run_pid_q != '0))
                    ? fps_remap(run_prio_q, expired || runnable) : run_prio_q;

  // item processing
  always_comb begin
    state_d    = ST_IDLE;
    run_pid_d  = run_pid_q;
    run_prio_d = run_prio_q;
    depth_d    = depth_q;
    pend_d     = pend_q;
    req_d      = req_q;
    qcmd       = '0;
    qnew       = in_entry;
    res        = '0;
    res.dprio  = run_prio_q;

    if (state_q == ST_INS) begin
      // requeue the departing process
      qcmd.ins = 1'b1;
      qnew     = req_q;
    end else if (accept) begin
      unique case (action)
        ACT_RESCHED: begin
          if (depth_q != '0) begin
            pend_d       = 1'b1;
            res.deferred = 1'b1;
          end
        end
        ACT_DSTART: begin
          if (depth_q == '0) begin
            pend_d = 1'b0;
          end
          if (depth_q != DEPTH_MAX) begin
            depth_d = depth_q + DEPTH_W'(1);
          end
        end
        ACT_DSTOP: begin
          if (depth_q == '0) begin
            res.status = 1'b1;
          end else begin
            depth_d = depth_q - DEPTH_W'(1);
          end
        end
        ACT_ENQ: begin
          if (count_q == CNT_W'(MAX_PROCS)) begin
            res.status = 1'b1;
          end else begin
            qcmd.ins = 1'b1;
          end
        end
        default: ;
      endcase

      if (resched) begin
        run_prio_d = upd_prio;
        res.dprio  = upd_prio;
        if (count_q == '0) begin
          res.status = !runnable;
        end else if (!(runnable && (upd_prio > head.prio))) begin
          // dispatch the head
          qcmd.pop     = 1'b1;
          run_pid_d    = head.pid;
          run_prio_d   = head.prio;
          res.switched = 1'b1;
          if (group == GRP_TS) begin
            res.qvalid  = 1'b1;
            res.quantum = fps_quantum(head.prio);
          end else if (group == GRP_PS) begin
            res.qvalid  = 1'b1;
            res.quantum = fixq_q;
          end
          if (runnable) begin
            state_d    = ST_INS;
            req_d.pid  = run_pid_q;
            req_d.prio = upd_prio;
          end
        end
      end
    end

    res.pid = run_pid_d;
    count_d = count_q + CNT_W'(qcmd.ins) - CNT_W'(qcmd.pop);
  end

  // output register
  always_comb begin
    mval_d = mval_q;
    mres_d = mres_q;
    if (accept) begin
      mval_d = 1'b1;
      mres_d = res;
    end else if (m_axis_tready) begin
      mval_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fixq_q     <= QUANT_W'(2);
      run_pid_q  <= '0;
      run_prio_q <= '0;
      count_q    <= '0;
      depth_q    <= '0;
      pend_q     <= 1'b0;
      mval_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      run_pid_q  <= run_pid_d;
      run_prio_q <= run_prio_d;
      count_q    <= count_d;
      depth_q    <= depth_d;
      pend_q     <= pend_d;
      mval_q     <= mval_d;
      if (cfg_valid_i && cfg_ready_o) begin
        fixq_q <= cfg_data_i;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    mres_q <= mres_d;
  end

  fps_queue #(
    .MAX_PROCS (MAX_PROCS),
    .CNT_W     (CNT_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (qcmd),
    .new_i   (qnew),
    .count_i (count_q),
    .head_o  (head)
  );

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = {{(32 - $bits(fps_result_t)){1'b0}}, mres_q};

  // checks
  `FPS_ASSERT_NEXT(a_ins_one_cycle, clk_i, rst_ni, state_q == ST_INS, state_q == ST_IDLE)
  `FPS_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, accept, m_axis_tvalid)
  `FPS_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(MAX_PROCS))
  `FPS_ASSERT_IMPLIES(a_requeue_after_switch, clk_i, rst_ni, state_d == ST_INS,
                      accept && res.switched)

endmodule

`default_nettype wire

@@ tb/fps_checker.sv @@
// ---------------------------------------------------------------------------
// fps_checker
// watches the config, input and output channels of the priority scheduler,
// predicts each result word from its own copy of the scheduler state and
// compares every field against the oldest prediction still waiting
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fps_checker
  import fps_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [QUANT_W-1:0] cfg_data_i,
  input  wire logic               in_tvalid_i,
  input  wire logic               in_tready_i,
  input  wire logic [15:0]        in_tdata_i,   // still_runnable, slice_expired,
                                                // old_group[1:0], ready_pid[5:0],
                                                // ready_priority[5:0]
  input  wire logic [1:0]         in_tuser_i,   // action[1:0]
  input  wire logic               out_tvalid_i,
  input  wire logic               out_tready_i,
  input  wire logic [31:0]        out_tdata_i,  // status, switched, deferred,
                                                // running_pid[5:0],
                                                // departing_priority[5:0],
                                                // quantum_valid, quantum[9:0],
                                                // zero fill
  output int                      fail_count_o,
  output int                      pending_o
);

  localparam logic [5:0] LAST_ROW    = 6'd59;
  localparam int         QUEUE_DEPTH = MAX_PROCS_DEF;

  // one result word split into its fields
  typedef struct packed {
    logic         status;
    logic         switched;
    logic         deferred;
    logic [5:0]   pid;
    logic [5:0]   dprio;
    logic         qvalid;
    logic [9:0]   quantum;
  } outcome_t;

  // shadow scheduler state
  logic [QUANT_W-1:0] slice_fixed;
  logic [5:0]         cur_pid;
  logic [5:0]         cur_prio;
  fps_entry_t         ready_q[$];
  logic [7:0]         nest_depth;
  logic               retry_held;

  outcome_t           outcomes_due[$];
  outcome_t           got;
  outcome_t           want;
  int                 n_words;

  task automatic note_fail(input string msg);
    $display("[%0t] scheduler check: %s", $time, msg);
    fail_count_o++;
  endtask

  // priorities past the last dispatch row use the last row
  function automatic logic [5:0] clamp_prio(input logic [5:0] p);
    return (p > LAST_ROW) ? LAST_ROW : p;
  endfunction

  function automatic logic [5:0] cpu_bound_prio(input logic [5:0] p);
    logic [5:0] i;
    i = clamp_prio(p);
    return (i <= 6'd10) ? 6'd0 : i - 6'd10;
  endfunction

  function automatic logic [5:0] io_bound_prio(input logic [5:0] p);
    logic [5:0] i;
    i = clamp_prio(p);
    if (i < 10)       return 6'd50;
    else if (i < 20)  return 6'd51;
    else if (i < 30)  return 6'd52;
    else if (i < 35)  return 6'd53;
    else if (i < 40)  return 6'd54;
    else if (i < 45)  return 6'd55;
    else if (i == 45) return 6'd56;
    else if (i == 46) return 6'd57;
    else if (i < 59)  return 6'd58;
    else              return 6'd59;
  endfunction

  function automatic logic [9:0] slice_by_prio(input logic [5:0] p);
    logic [5:0] i;
    i = clamp_prio(p);
    if (i < 10)      return 10'd200;
    else if (i < 20) return 10'd160;
    else if (i < 30) return 10'd120;
    else if (i < 40) return 10'd80;
    else if (i < 59) return 10'd40;
    else             return 10'd20;
  endfunction

  // sorted insert, behind every entry of equal or higher priority
  function automatic logic enqueue_proc(input logic [5:0] pid_in, input logic [5:0] prio_in);
    fps_entry_t e;
    int         pos;
    if (ready_q.size() >= QUEUE_DEPTH) return 1'b0;
    pos = 0;
    while (pos < ready_q.size() && ready_q[pos].prio >= prio_in) pos++;
    e.pid  = pid_in;
    e.prio = prio_in;
    ready_q.insert(pos, e);
    return 1'b1;
  endfunction

  function automatic void dispatch_attempt(input logic runnable, input logic expired,
                                           input logic [1:0] grp, inout outcome_t r);
    fps_entry_t head;
    // inside a defer window only remember that a reschedule was asked for
    if (nest_depth != 0) begin
      retry_held = 1'b1;
      r.deferred = 1'b1;
      return;
    end
    // time-sharing feedback, the null process keeps its priority
    if (grp == GRP_TS && cur_pid != 0)
      cur_prio = (expired || runnable) ? cpu_bound_prio(cur_prio) : io_bound_prio(cur_prio);
    r.dprio = cur_prio;
    if (ready_q.size() == 0) begin
      if (!runnable) r.status = 1'b1;
      return;
    end
    if (runnable && cur_prio > ready_q[0].prio) return;
    // head leaves before the old process goes back in
    head = ready_q.pop_front();
    if (runnable) void'(enqueue_proc(cur_pid, cur_prio));
    cur_pid    = head.pid;
    cur_prio   = head.prio;
    r.switched = 1'b1;
    if (grp == GRP_TS) begin
      r.qvalid  = 1'b1;
      r.quantum = slice_by_prio(head.prio);
    end else if (grp == GRP_PS) begin
      r.qvalid  = 1'b1;
      r.quantum = slice_fixed;
    end
  endfunction

  function automatic outcome_t schedule_step(input fps_action_e act, input logic [15:0] w);
    outcome_t r;
    r       = '0;
    r.dprio = cur_prio;
    case (act)
      ACT_RESCHED: dispatch_attempt(w[0], w[1], w[3:2], r);
      ACT_DSTART: begin
        if (nest_depth == 0) retry_held = 1'b0;
        if (nest_depth != DEPTH_MAX) nest_depth++;
      end
      ACT_DSTOP: begin
        if (nest_depth == 0) begin
          r.status = 1'b1;
        end else begin
          nest_depth--;
          if (nest_depth == 0 && retry_held) dispatch_attempt(w[0], w[1], w[3:2], r);
        end
      end
      default: begin
        if (!enqueue_proc(w[9:4], w[15:10])) r.status = 1'b1;
      end
    endcase
    r.pid = cur_pid;
    return r;
  endfunction

  // predict on every accepted input word, compare on every accepted result word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_fixed  = 10'd2;
      cur_pid      = '0;
      cur_prio     = '0;
      ready_q.delete();
      nest_depth   = '0;
      retry_held   = 1'b0;
      outcomes_due.delete();
      n_words      = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) slice_fixed = cfg_data_i;
      if (in_tvalid_i && in_tready_i)
        outcomes_due.push_back(schedule_step(fps_action_e'(in_tuser_i), in_tdata_i));
      if (out_tvalid_i && out_tready_i) begin
        n_words++;
        if (outcomes_due.size() == 0) begin
          note_fail($sformatf("result word %0d (%h) with nothing expected",
                              n_words, out_tdata_i));
        end else begin
          want = outcomes_due.pop_front();
          got  = out_tdata_i[25:0];
          got  = {out_tdata_i[0], out_tdata_i[1], out_tdata_i[2], out_tdata_i[8:3],
                  out_tdata_i[14:9], out_tdata_i[15], out_tdata_i[25:16]};
          if (got.status != want.status)
            note_fail($sformatf("word %0d status: got %0d, expected %0d",
                                n_words, got.status, want.status));
          if (got.switched != want.switched)
            note_fail($sformatf("word %0d switched: got %0d, expected %0d",
                                n_words, got.switched, want.switched));
          if (got.deferred != want.deferred)
            note_fail($sformatf("word %0d deferred: got %0d, expected %0d",
                                n_words, got.deferred, want.deferred));
          if (got.pid != want.pid)
            note_fail($sformatf("word %0d running_pid: got %0d, expected %0d",
                                n_words, got.pid, want.pid));
          if (got.dprio != want.dprio)
            note_fail($sformatf("word %0d departing_priority: got %0d, expected %0d",
                                n_words, got.dprio, want.dprio));
          if (got.qvalid != want.qvalid)
            note_fail($sformatf("word %0d quantum_valid: got %0d, expected %0d",
                                n_words, got.qvalid, want.qvalid));
          if (got.quantum != want.quantum)
            note_fail($sformatf("word %0d quantum: got %0d, expected %0d",
                                n_words, got.quantum, want.quantum));
          if (out_tdata_i[31:26] != '0)
            note_fail($sformatf("word %0d fill bits: got %h, expected 0",
                                n_words, out_tdata_i[31:26]));
        end
      end
      pending_o = outcomes_due.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// stimulus for the priority scheduler: a directed opening over the special
// cases, then random well-formed and noisy word streams under three idling
// patterns and several fixed_quantum settings; the checker judges results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fps_pkg::*;

  localparam int         PHASE_WORDS = 300;
  localparam int         HOLD_CYCLES = 300;
  localparam int         WD_LIMIT    = 3000;
  localparam int         MODE_MIX    = 0;
  localparam int         MODE_FILL   = 1;
  localparam int         MODE_DRAIN  = 2;
  localparam logic [1:0] GRP_OTHER   = 2'd2;
  localparam logic [1:0] GRP_SPARE   = 2'd3;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic [QUANT_W-1:0] cfg_data_i     = '0;
  logic               s_axis_tvalid  = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata   = '0;
  logic [1:0]         s_axis_tuser   = ACT_RESCHED;
  logic               m_axis_tvalid;
  logic               m_axis_tready  = 1'b0;
  logic [31:0]        m_axis_tdata;

  int fail_count;
  int pending;
  int src_idle  = 11;
  int dst_idle  = 59;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int n_sent    = 0;
  int quiet_cycles = 0;

  feedback_priority_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fps_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_tvalid_i  (s_axis_tvalid),
    .in_tready_i  (s_axis_tready),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .out_tvalid_i (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_i  (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WD_LIMIT);
      $display("** feedback_priority_scheduler: FAILED **");
      $finish;
    end
  end

  function automatic logic [15:0] pack_fields(input logic run, input logic expd,
                                              input logic [1:0] grp,
                                              input logic [5:0] pid, input logic [5:0] prio);
    return {prio, pid, grp, expd, run};
  endfunction

  // mostly legal priorities, now and then one above the last table row (60 to 63)
  function automatic logic [5:0] pick_prio();
    return ($urandom_range(9) == 0) ? 6'($urandom_range(63, 60)) : 6'($urandom_range(59));
  endfunction

  function automatic logic [15:0] random_fields(input logic run);
    return pack_fields(run, 1'($urandom_range(1)), 2'($urandom_range(3)),
                       6'($urandom_range(63)), pick_prio());
  endfunction

  // offer one input word, with a random gap in front, and wait for it to be taken
  task automatic send_item(input fps_action_e act, input logic [15:0] w);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    n_sent++;
  endtask

  // drop valid and wait until every result word is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_quantum(input logic [QUANT_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random(input int mode);
    int          r;
    int          enq_pct;
    logic        run;
    fps_action_e act;
    r       = $urandom_range(99);
    enq_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 5 : 35;
    run     = (mode == MODE_DRAIN) ? ($urandom_range(3) == 0) : 1'($urandom_range(1));
    if (r < enq_pct)           act = ACT_ENQ;
    else if (r < enq_pct + 4)  act = ACT_DSTART;
    else if (r < enq_pct + 12) act = ACT_DSTOP;
    else                       act = ACT_RESCHED;
    send_item(act, random_fields(run));
  endtask

  // balanced defer window with a few random words inside
  task automatic send_defer_nest();
    int opens;
    opens = $urandom_range(1, 3);
    repeat (opens) send_item(ACT_DSTART, random_fields(1'($urandom_range(1))));
    repeat ($urandom_range(1, 4)) send_random(MODE_MIX);
    repeat (opens) send_item(ACT_DSTOP, random_fields(1'($urandom_range(1))));
  endtask

  task automatic random_run(input int count);
    int target;
    int mode;
    target = n_sent + count;
    mode   = MODE_MIX;
    while (n_sent < target) begin
      if ($urandom_range(79) == 0) mode = $urandom_range(MODE_DRAIN);
      if ($urandom_range(19) == 0) send_defer_nest();
      else                         send_random(mode);
    end
  endtask

  // opening sequence over the corner cases
  task automatic directed_run();
    // stop with no defer open, then reschedules on an empty queue
    send_item(ACT_DSTOP,   pack_fields(1'b1, 1'b1, GRP_TS, 6'd63, 6'd63));
    send_item(ACT_RESCHED, pack_fields(1'b0, 1'b0, GRP_TS, 6'd0, 6'd0));
    send_item(ACT_RESCHED, pack_fields(1'b1, 1'b0, GRP_TS, 6'd0, 6'd0));
    // extremes of pid and priority, one priority past the table, equal priorities
    send_item(ACT_ENQ,     pack_fields(1'b0, 1'b0, GRP_TS, 6'd63, 6'd59));
    send_item(ACT_ENQ,     pack_fields(1'b1, 1'b1, GRP_SPARE, 6'd5, 6'd63));
    send_item(ACT_ENQ,     pack_fields(1'b0, 1'b0, GRP_TS, 6'd1, 6'd0));
    send_item(ACT_ENQ,     pack_fields(1'b0, 1'b1, GRP_PS, 6'd62, 6'd59));
    // null process yields, then cpu-bound and io-bound feedback
    send_item(ACT_RESCHED, pack_fields(1'b1, 1'b0, GRP_TS, 6'd0, 6'd0));
    send_item(ACT_RESCHED, pack_fields(1'b1, 1'b1, GRP_TS, 6'd0, 6'd0));
    send_item(ACT_RESCHED, pack_fields(1'b0, 1'b0, GRP_TS, 6'd0, 6'd0));
    // proportional-share and other groups
    send_item(ACT_RESCHED, pack_fields(1'b0, 1'b1, GRP_PS, 6'd0, 6'd0));
    send_item(ACT_ENQ,     pack_fields(1'b0, 1'b0, GRP_TS, 6'd42, 6'd30));
    send_item(ACT_RESCHED, pack_fields(1'b0, 1'b0, GRP_OTHER, 6'd0, 6'd0));
    send_item(ACT_ENQ,     pack_fields(1'b0, 1'b0, GRP_TS, 6'd7, 6'd10));
    send_item(ACT_RESCHED, pack_fields(1'b1, 1'b0, GRP_SPARE, 6'd0, 6'd0));
    // nested defer with a replay on the last stop
    send_item(ACT_DSTART,  pack_fields(1'b0, 1'b0, GRP_TS, 6'd0, 6'd0));
    send_item(ACT_RESCHED, pack_fields(1'b1, 1'b1, GRP_TS, 6'd0, 6'd0));
    send_item(ACT_DSTART,  pack_fields(1'b0, 1'b0, GRP_TS, 6'd0, 6'd0));
    send_item(ACT_ENQ,     pack_fields(1'b0, 1'b0, GRP_TS, 6'd0, 6'd20));
    send_item(ACT_DSTOP,   pack_fields(1'b1, 1'b0, GRP_TS, 6'd0, 6'd0));
    send_item(ACT_DSTOP,   pack_fields(1'b0, 1'b1, GRP_TS, 6'd0, 6'd0));
    // a fresh window clears the held attempt, so no replay here
    send_item(ACT_DSTART,  pack_fields(1'b0, 1'b0, GRP_TS, 6'd0, 6'd0));
    send_item(ACT_DSTOP,   pack_fields(1'b0, 1'b0, GRP_TS, 6'd0, 6'd0));
    send_item(ACT_RESCHED, pack_fields(1'b0, 1'b1, GRP_PS, 6'd0, 6'd0));
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset value of fixed_quantum, sender idles lightly, receiver heavily
    directed_run();
    hold_req <= hold_req + 1;
    repeat (70) send_item(ACT_ENQ, random_fields(1'b0));
    random_run(PHASE_WORDS);
    settle();

    // largest quantum, roles of the two sides swapped
    write_quantum(10'd1023);
    src_idle = 59;
    dst_idle <= 11;
    random_run(PHASE_WORDS);
    settle();

    // quantum of 1, no idling, depth saturation and unwind
    write_quantum(10'd1);
    src_idle = 0;
    dst_idle <= 0;
    repeat (256) send_item(ACT_DSTART, random_fields(1'($urandom_range(1))));
    send_item(ACT_RESCHED, random_fields(1'b1));
    repeat (255) send_item(ACT_DSTOP, random_fields(1'($urandom_range(1))));
    send_item(ACT_DSTOP, random_fields(1'b0));
    random_run(PHASE_WORDS / 2);
    settle();

    write_quantum(10'($urandom_range(1022, 2)));
    random_run(PHASE_WORDS / 2);
    settle();

    repeat (4) @(negedge clk_i);
    if (fail_count == 0)
      $display("** feedback_priority_scheduler: PASSED **");
    else
      $display("** feedback_priority_scheduler: FAILED **");
    $finish;
  end

endmodule

@@ feedback_priority_scheduler.f @@
+incdir+src
src/fps_pkg.sv
src/fps_cell.sv
src/fps_queue.sv
src/feedback_priority_scheduler.sv
tb/fps_checker.sv
tb/tb.sv
